[sv/lrrm_pkg.sv]
// lrrm_pkg: shared types, constants and codes for the lock revoke/retry manager
// no dependencies; imported by every module of the block
`default_nettype none
package lrrm_pkg;
    localparam int NUM_LOCKS    = 16;
    localparam int NUM_CLIENTS  = 16;
    localparam int WAITER_DEPTH = 8;
    localparam int LOCK_W  = 4;
    localparam int CLI_W   = 4;
    localparam int HEAD_W  = 3;
    localparam int CNT_W   = 4;
    localparam int SLOT_W  = LOCK_W + HEAD_W;
    localparam int QDEPTH  = 2;

    typedef enum logic [1:0] {
        MODE_FREE = 2'd0, MODE_EXCL = 2'd1, MODE_REVOKING = 2'd2, MODE_RETRYING = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_RETRY = 2'd1, ST_REJECT = 2'd2, ST_FULL = 2'd3
    } status_t;

    localparam logic FUNC_ACQUIRE = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;
    localparam logic MSG_REVOKE   = 1'b0;
    localparam logic MSG_RETRY    = 1'b1;

    // classified request passed from front to back
    typedef struct packed {
        logic              func;
        logic [CLI_W-1:0]  client;
        logic [LOCK_W-1:0] lock;
        logic              bad;
    } req_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0, BK_SCAN = 2'd1, BK_DONE = 2'd2
    } bk_state_t;
endpackage
`default_nettype wire

[sv/lrrm_front.sv]
// lrrm_front: accepts request beats, range-checks them and queues them
// depends on lrrm_pkg
`default_nettype none
module lrrm_front (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    input  wire                     func,
    input  wire [3:0]               client_id,
    input  wire [3:0]               lock_index,
    output logic                    busy,
    output logic                    q_valid,
    output lrrm_pkg::req_t          q_data,
    input  wire                     q_pop
);
    import lrrm_pkg::*;

    req_t       mem_reg [QDEPTH];
    logic       wr_reg, wr_next, rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    req_t       in_req;

    // classify the incoming beat
    always_comb
    begin
        in_req.func   = func;
        in_req.client = client_id;
        in_req.lock   = lock_index;
        in_req.bad    = (32'(lock_index) >= NUM_LOCKS) || (32'(client_id) >= NUM_CLIENTS);
    end

    assign busy    = (cnt_reg == 2'(QDEPTH));
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = mem_reg[rd_reg];

    // pointer update
    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = q_pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_req;
        end
    end
endmodule
`default_nettype wire

[sv/lrrm_back.sv]
// lrrm_back: per-lock state machine with waiter queue memory scanned one slot a cycle
// depends on lrrm_pkg
`default_nettype none
module lrrm_back (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     q_valid,
    input  lrrm_pkg::req_t          q_data,
    output logic                    q_pop,
    output logic                    res_strobe,
    output logic [1:0]              reply_status,
    output logic                    msg_valid,
    output logic                    msg_kind,
    output logic [3:0]              msg_client,
    output logic [3:0]              msg_lock
);
    import lrrm_pkg::*;

    mode_t             mode_reg  [NUM_LOCKS];
    logic              ovld_reg  [NUM_LOCKS];
    logic [CLI_W-1:0]  owner_reg [NUM_LOCKS];
    logic [HEAD_W-1:0] head_reg  [NUM_LOCKS];
    logic [CNT_W-1:0]  count_reg [NUM_LOCKS];
    logic [CLI_W-1:0]  wq_mem    [NUM_LOCKS*WAITER_DEPTH];

    bk_state_t         state_reg, state_next;
    req_t              req_reg;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              dup_reg, dup_next;
    logic [CLI_W-1:0]  rdata_reg;
    logic              rvalid_reg;
    logic [SLOT_W-1:0] raddr;
    logic              rd_en;

    mode_t             cur_mode;
    logic [CLI_W-1:0]  cur_owner;
    logic [HEAD_W-1:0] cur_head;
    logic [CNT_W-1:0]  cur_cnt;
    logic              owns;
    logic              dup_all;
    logic [CLI_W-1:0]  head_client;

    logic [1:0]        st;
    logic              mv, mk;
    logic [CLI_W-1:0]  mc;
    logic              w_mode, w_owner, w_ovld, w_pop, w_push;
    mode_t             new_mode;
    logic              new_ovld;
    logic [CLI_W-1:0]  new_owner;

    assign cur_mode  = mode_reg[req_reg.lock];
    assign cur_owner = owner_reg[req_reg.lock];
    assign cur_head  = head_reg[req_reg.lock];
    assign cur_cnt   = count_reg[req_reg.lock];
    assign owns      = ovld_reg[req_reg.lock] && (cur_owner == req_reg.client);

    // scan address: slot idx of the queue, head first
    assign raddr = {req_reg.lock, HEAD_W'(cur_head + HEAD_W'(idx_reg))};
    assign rd_en = (state_reg == BK_SCAN) && (idx_reg < cur_cnt);

    // queue memory read, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= wq_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= rd_en;
        end
    end

    // head entry is first one read in the scan
    logic [CLI_W-1:0] head_cap_reg;
    logic             first_reg;
    always_ff @(posedge clk)
    begin
        if (rvalid_reg && first_reg)
        begin
            head_cap_reg <= rdata_reg;
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b0;
        end
        else if (state_reg != BK_SCAN)
        begin
            first_reg <= 1'b1;
        end
        else if (rvalid_reg)
        begin
            first_reg <= 1'b0;
        end
    end
    assign head_client = head_cap_reg;

    // take the next request beat from the front while idle
    assign q_pop = (state_reg == BK_IDLE) && q_valid;

    // next state and scan bookkeeping
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        dup_next   = dup_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    idx_next   = '0;
                    dup_next   = 1'b0;
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if (rvalid_reg && rdata_reg == req_reg.client)
                begin
                    dup_next = 1'b1;
                end
                if (rd_en)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                else if (!rvalid_reg)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign dup_all = dup_reg;

    // decision, made in the done cycle
    always_comb
    begin
        st = ST_REJECT; mv = 1'b0; mk = MSG_REVOKE; mc = '0;
        w_mode = 1'b0; w_owner = 1'b0; w_ovld = 1'b0; w_pop = 1'b0; w_push = 1'b0;
        new_mode = cur_mode; new_ovld = 1'b0; new_owner = req_reg.client;
        if (!req_reg.bad)
        begin
            if (req_reg.func == FUNC_ACQUIRE)
            begin
                case (cur_mode)
                    MODE_FREE:
                    begin
                        st = ST_OK; w_mode = 1'b1; new_mode = MODE_EXCL;
                        w_owner = 1'b1; w_ovld = 1'b1; new_ovld = 1'b1;
                    end
                    MODE_EXCL, MODE_REVOKING:
                    begin
                        if (owns) st = ST_REJECT;
                        else if (dup_all) st = ST_REJECT;
                        else if (32'(cur_cnt) >= WAITER_DEPTH) st = ST_FULL;
                        else
                        begin
                            st = ST_RETRY; w_push = 1'b1;
                            if (cur_mode == MODE_EXCL)
                            begin
                                w_mode = 1'b1; new_mode = MODE_REVOKING;
                                mv = 1'b1; mk = MSG_REVOKE; mc = cur_owner;
                            end
                        end
                    end
                    default:
                    begin
                        if (cur_cnt != '0 && head_client == req_reg.client)
                        begin
                            st = ST_OK; w_pop = 1'b1;
                            w_owner = 1'b1; w_ovld = 1'b1; new_ovld = 1'b1;
                            w_mode = 1'b1;
                            if (cur_cnt == CNT_W'(1)) new_mode = MODE_EXCL;
                            else
                            begin
                                new_mode = MODE_REVOKING;
                                mv = 1'b1; mk = MSG_REVOKE; mc = req_reg.client;
                            end
                        end
                        else if (dup_all) st = ST_REJECT;
                        else if (32'(cur_cnt) >= WAITER_DEPTH) st = ST_FULL;
                        else
                        begin
                            st = ST_RETRY; w_push = 1'b1;
                        end
                    end
                endcase
            end
            else if (owns)
            begin
                case (cur_mode)
                    MODE_EXCL:
                    begin
                        st = ST_OK; w_mode = 1'b1; new_mode = MODE_FREE;
                        w_ovld = 1'b1; new_ovld = 1'b0;
                    end
                    MODE_REVOKING:
                    begin
                        st = ST_OK; w_ovld = 1'b1; new_ovld = 1'b0; w_mode = 1'b1;
                        if (cur_cnt != '0)
                        begin
                            new_mode = MODE_RETRYING;
                            mv = 1'b1; mk = MSG_RETRY; mc = head_client;
                        end
                        else new_mode = MODE_FREE;
                    end
                    default: st = ST_REJECT;
                endcase
            end
        end
    end

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            idx_reg   <= '0;
            dup_reg   <= 1'b0;
            for (int i = 0; i < NUM_LOCKS; i++)
            begin
                mode_reg[i]  <= MODE_FREE;
                ovld_reg[i]  <= 1'b0;
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            dup_reg   <= dup_next;
            if (state_reg == BK_DONE)
            begin
                if (w_mode) mode_reg[req_reg.lock] <= new_mode;
                if (w_ovld) ovld_reg[req_reg.lock] <= new_ovld;
                if (w_pop)
                begin
                    head_reg[req_reg.lock]  <= cur_head + HEAD_W'(1);
                    count_reg[req_reg.lock] <= cur_cnt - CNT_W'(1);
                end
                if (w_push) count_reg[req_reg.lock] <= cur_cnt + CNT_W'(1);
            end
        end
    end

    // payload registers: request, owner table, queue memory write
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            req_reg <= q_data;
        end
        if (state_reg == BK_DONE && w_owner)
        begin
            owner_reg[req_reg.lock] <= new_owner;
        end
        if (state_reg == BK_DONE && w_push)
        begin
            wq_mem[{req_reg.lock, HEAD_W'(cur_head + HEAD_W'(cur_cnt))}] <= req_reg.client;
        end
    end

    // result beat
    always_comb
    begin
        res_strobe   = (state_reg == BK_DONE);
        reply_status = st;
        msg_valid    = mv;
        msg_kind     = mv ? mk : 1'b0;
        msg_client   = mv ? mc : '0;
        msg_lock     = mv ? req_reg.lock : '0;
    end
endmodule
`default_nettype wire

[sv/lock_revoke_retry_manager_unit.sv]
// lock_revoke_retry_manager_unit: top level joining request front end and lock back end
// depends on lrrm_pkg, lrrm_front, lrrm_back
//
// channel  | signals                                   | handshake
// request  | func, client_id, lock_index               | start high, busy low
// result   | reply_status, msg_valid/kind/client/lock  | done strobe, one cycle
//
// a request's result beat follows its acceptance through the front queue, the back
// end's scan state (one read per waiter slot of the lock's queue for the duplicate
// and head check, plus the registered read) and its done state
// the front holds up to two requests; busy rises while both are held
// reset clears all lock modes, owner flags and queue counts at once
// results cannot be stalled: each shows for exactly one cycle under done
`default_nettype none
module lock_revoke_retry_manager_unit (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    output logic       busy,
    input  wire        func,
    input  wire [3:0]  client_id,
    input  wire [3:0]  lock_index,
    output logic       done,
    output logic [1:0] reply_status,
    output logic       msg_valid,
    output logic       msg_kind,
    output logic [3:0] msg_client,
    output logic [3:0] msg_lock
);
    import lrrm_pkg::*;

    logic q_valid, q_pop;
    req_t q_data;

    lrrm_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .func(func),
        .client_id(client_id), .lock_index(lock_index), .busy(busy),
        .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
    );

    lrrm_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data),
        .q_pop(q_pop), .res_strobe(done), .reply_status(reply_status),
        .msg_valid(msg_valid), .msg_kind(msg_kind), .msg_client(msg_client),
        .msg_lock(msg_lock)
    );

    // no pop from an empty queue
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("pop from empty request queue");
    // a message always carries an ok or retry status
    a_msg_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && msg_valid) |-> (reply_status == ST_OK || reply_status == ST_RETRY))
        else $error("message with reject status");
    // no message fields without a message
    a_msg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !msg_valid) |-> (msg_client == 4'd0 && msg_lock == 4'd0 && !msg_kind))
        else $error("stray message fields");
endmodule
`default_nettype wire

[sim/tb.sv]
// tb: self-checking bench for lock_revoke_retry_manager_unit
// depends on lrrm_pkg and the block's rtl; drives requests, checks each result beat
`default_nettype none
module tb;
    import lrrm_pkg::*;

    // one expected result beat
    typedef struct packed {
        status_t    status;
        logic       mvalid;
        logic       mkind;
        logic [3:0] mclient;
        logic [3:0] mlock;
    } reply_t;

    // directed row: request plus optional typed-in answer
    typedef struct {
        logic       fn;
        logic [3:0] cli;
        logic [3:0] lk;
        bit         typed;
        reply_t     ans;
    } row_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       func;
    logic [3:0] client_id;
    logic [3:0] lock_index;
    logic       done;
    logic [1:0] reply_status;
    logic       msg_valid;
    logic       msg_kind;
    logic [3:0] msg_client;
    logic [3:0] msg_lock;

    lock_revoke_retry_manager_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .func(func), .client_id(client_id), .lock_index(lock_index),
        .done(done), .reply_status(reply_status), .msg_valid(msg_valid),
        .msg_kind(msg_kind), .msg_client(msg_client), .msg_lock(msg_lock)
    );

    // shadow of the lock table
    mode_t      shadow_mode [NUM_LOCKS];
    logic       shadow_has_owner [NUM_LOCKS];
    logic [3:0] shadow_owner [NUM_LOCKS];
    logic [3:0] shadow_waiters [NUM_LOCKS][$];

    reply_t pending_replies [$];
    int     error_count;
    int     reply_count;
    int     msg_count;
    int     full_count;
    int     cycle_count;
    int     sent_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report(input string what);
        error_count++;
        $display("error @%0d: %s", cycle_count, what);
    endtask

    function automatic bit in_queue(input int lk, input logic [3:0] c);
        for (int i = 0; i < shadow_waiters[lk].size(); i++)
            if (shadow_waiters[lk][i] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    // join the waiter queue, reporting retry, duplicate or full
    function automatic status_t join_queue(input int lk, input logic [3:0] c);
        if (in_queue(lk, c))
            return ST_REJECT;
        if (shadow_waiters[lk].size() >= WAITER_DEPTH)
            return ST_FULL;
        shadow_waiters[lk].insert(shadow_waiters[lk].size(), c);
        return ST_RETRY;
    endfunction

    // apply one request to the shadow table and return its reply
    function automatic reply_t predict_reply(input logic fn, input logic [3:0] c,
                                             input logic [3:0] lk);
        reply_t r;
        bit     owns;
        r = '{ST_REJECT, 1'b0, 1'b0, 4'd0, 4'd0};
        owns = shadow_has_owner[lk] && shadow_owner[lk] == c;
        if (fn == FUNC_ACQUIRE)
        begin
            case (shadow_mode[lk])
                MODE_FREE:
                begin
                    shadow_owner[lk] = c;
                    shadow_has_owner[lk] = 1'b1;
                    shadow_mode[lk] = MODE_EXCL;
                    r.status = ST_OK;
                end
                MODE_EXCL, MODE_REVOKING:
                begin
                    if (!owns)
                    begin
                        r.status = join_queue(lk, c);
                        if (r.status == ST_RETRY && shadow_mode[lk] == MODE_EXCL)
                        begin
                            shadow_mode[lk] = MODE_REVOKING;
                            r.mvalid = 1'b1;
                            r.mkind = MSG_REVOKE;
                            r.mclient = shadow_owner[lk];
                        end
                    end
                end
                default:
                begin
                    if (shadow_waiters[lk].size() != 0 && shadow_waiters[lk][0] == c)
                    begin
                        shadow_waiters[lk].delete(0);
                        shadow_owner[lk] = c;
                        shadow_has_owner[lk] = 1'b1;
                        if (shadow_waiters[lk].size() == 0)
                            shadow_mode[lk] = MODE_EXCL;
                        else
                        begin
                            shadow_mode[lk] = MODE_REVOKING;
                            r.mvalid = 1'b1;
                            r.mkind = MSG_REVOKE;
                            r.mclient = c;
                        end
                        r.status = ST_OK;
                    end
                    else
                        r.status = join_queue(lk, c);
                end
            endcase
        end
        else if (owns)
        begin
            if (shadow_mode[lk] == MODE_EXCL)
            begin
                shadow_mode[lk] = MODE_FREE;
                shadow_has_owner[lk] = 1'b0;
                r.status = ST_OK;
            end
            else if (shadow_mode[lk] == MODE_REVOKING)
            begin
                shadow_has_owner[lk] = 1'b0;
                if (shadow_waiters[lk].size() != 0)
                begin
                    shadow_mode[lk] = MODE_RETRYING;
                    r.mvalid = 1'b1;
                    r.mkind = MSG_RETRY;
                    r.mclient = shadow_waiters[lk][0];
                end
                else
                    shadow_mode[lk] = MODE_FREE;
                r.status = ST_OK;
            end
        end
        if (r.mvalid)
            r.mlock = lk;
        return r;
    endfunction

    // issue one request beat; drive at falling edge, wait for acceptance
    task automatic send_request(input logic fn, input logic [3:0] c, input logic [3:0] lk,
                                input bit typed, input reply_t ans);
        reply_t r;
        @(negedge clk);
        start <= 1'b1;
        func <= fn;
        client_id <= c;
        lock_index <= lk;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = predict_reply(fn, c, lk);
        if (typed && r != ans)
            report($sformatf("table answer disagrees with predictor fn=%0d c=%0d lk=%0d",
                             fn, c, lk));
        pending_replies.insert(pending_replies.size(), r);
        sent_count++;
    endtask

    task automatic idle_cycles(input int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // result checking at each rising edge
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin : check_beat
            reply_t e;
            if (pending_replies.size() == 0)
                report("result beat with nothing expected");
            else
            begin
                e = pending_replies[0];
                pending_replies.delete(0);
                reply_count++;
                if (msg_valid)
                    msg_count++;
                if (reply_status == ST_FULL)
                    full_count++;
                if (reply_status !== e.status)
                    report($sformatf("reply_status %0d expected %0d", reply_status, e.status));
                if (msg_valid !== e.mvalid)
                    report($sformatf("msg_valid %0d expected %0d", msg_valid, e.mvalid));
                if (msg_kind !== e.mkind)
                    report($sformatf("msg_kind %0d expected %0d", msg_kind, e.mkind));
                if (msg_client !== e.mclient)
                    report($sformatf("msg_client %0d expected %0d", msg_client, e.mclient));
                if (msg_lock !== e.mlock)
                    report($sformatf("msg_lock %0d expected %0d", msg_lock, e.mlock));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // directed table: extremes and each special case
    localparam reply_t OKR  = '{ST_OK, 1'b0, 1'b0, 4'd0, 4'd0};
    localparam reply_t REJ  = '{ST_REJECT, 1'b0, 1'b0, 4'd0, 4'd0};
    localparam reply_t NONE = '{ST_OK, 1'b0, 1'b0, 4'd0, 4'd0};
    row_t plan [] = '{
        '{FUNC_ACQUIRE, 4'd0,  4'd0,  1, OKR},
        '{FUNC_ACQUIRE, 4'd0,  4'd0,  1, REJ},   // owner re-acquires
        '{FUNC_RELEASE, 4'd5,  4'd0,  1, REJ},   // release by non-owner
        '{FUNC_RELEASE, 4'd3,  4'd15, 1, REJ},   // release with no owner
        '{FUNC_ACQUIRE, 4'd15, 4'd15, 1, OKR},
        '{FUNC_RELEASE, 4'd15, 4'd15, 1, OKR},
        '{FUNC_ACQUIRE, 4'd1,  4'd0,  1, '{ST_RETRY, 1'b1, MSG_REVOKE, 4'd0, 4'd0}},
        '{FUNC_ACQUIRE, 4'd1,  4'd0,  1, REJ},   // duplicate waiter
        '{FUNC_ACQUIRE, 4'd2,  4'd0,  0, NONE},
        '{FUNC_ACQUIRE, 4'd3,  4'd0,  0, NONE},
        '{FUNC_ACQUIRE, 4'd4,  4'd0,  0, NONE},
        '{FUNC_ACQUIRE, 4'd5,  4'd0,  0, NONE},
        '{FUNC_ACQUIRE, 4'd6,  4'd0,  0, NONE},
        '{FUNC_ACQUIRE, 4'd7,  4'd0,  0, NONE},
        '{FUNC_ACQUIRE, 4'd8,  4'd0,  0, NONE},
        '{FUNC_ACQUIRE, 4'd9,  4'd0,  1, '{ST_FULL, 1'b0, 1'b0, 4'd0, 4'd0}},
        '{FUNC_RELEASE, 4'd0,  4'd0,  1, '{ST_OK, 1'b1, MSG_RETRY, 4'd1, 4'd0}},
        '{FUNC_RELEASE, 4'd1,  4'd0,  1, REJ},   // retrying lock has no owner
        '{FUNC_ACQUIRE, 4'd4,  4'd0,  1, REJ},   // waiter not at head, duplicate
        '{FUNC_ACQUIRE, 4'd10, 4'd0,  0, NONE},  // queue full while retrying
        '{FUNC_ACQUIRE, 4'd1,  4'd0,  1, '{ST_OK, 1'b1, MSG_REVOKE, 4'd1, 4'd0}},
        '{FUNC_RELEASE, 4'd1,  4'd0,  0, NONE},
        '{FUNC_ACQUIRE, 4'd2,  4'd0,  0, NONE}
    };

    // pick a lock; a few hot locks keep queues long
    function automatic logic [3:0] pick_lock();
        return ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 2)) : 4'($urandom);
    endfunction

    // pick a request that tends to move the lock forward
    task automatic pick_request(output logic fn, output logic [3:0] c, output logic [3:0] lk);
        lk = pick_lock();
        fn = 1'($urandom_range(0, 1));
        c = 4'($urandom);
        if ($urandom_range(0, 9) < 7)
        begin
            if (shadow_mode[lk] == MODE_RETRYING && shadow_waiters[lk].size() != 0)
            begin
                fn = FUNC_ACQUIRE;
                c = shadow_waiters[lk][0];
            end
            else if (shadow_has_owner[lk] && $urandom_range(0, 2) == 0)
            begin
                fn = FUNC_RELEASE;
                c = shadow_owner[lk];
            end
            else
                fn = FUNC_ACQUIRE;
        end
    endtask

    initial
    begin
        logic       fn;
        logic [3:0] c;
        logic [3:0] lk;
        int         burst;
        int         waited;
        rst_n = 1'b0;
        start = 1'b0;
        func = 1'b0;
        client_id = 4'd0;
        lock_index = 4'd0;
        error_count = 0;
        reply_count = 0;
        msg_count = 0;
        full_count = 0;
        cycle_count = 0;
        sent_count = 0;
        for (int i = 0; i < NUM_LOCKS; i++)
        begin
            shadow_mode[i] = MODE_FREE;
            shadow_has_owner[i] = 1'b0;
            shadow_owner[i] = 4'd0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (plan[i])
            send_request(plan[i].fn, plan[i].cli, plan[i].lk, plan[i].typed, plan[i].ans);

        // random bursts, mostly with gaps between them
        while (sent_count < 1925)
        begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++)
            begin
                pick_request(fn, c, lk);
                send_request(fn, c, lk, 1'b0, NONE);
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(0, 20));
        end
        idle_cycles(0);

        // drain
        waited = 0;
        while (pending_replies.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (30) @(posedge clk);
        if (pending_replies.size() != 0)
            report($sformatf("%0d results never arrived", pending_replies.size()));

        $display("covered %0d requests, %0d results, %0d messages, %0d queue-full replies",
                 sent_count, reply_count, msg_count, full_count);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
